// ----- rtl/core/command_packet_framer_crc16_core_macros.svh -----
// assertion helpers for the framer modules, used by the byte sequencer (cpf_back)
`ifndef COMMAND_PACKET_FRAMER_CRC16_CORE_MACROS_SVH
`define COMMAND_PACKET_FRAMER_CRC16_CORE_MACROS_SVH

// same-cycle implication, checked out of reset
`define CPF_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("framer check failed");

// next-cycle implication, checked out of reset
`define CPF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("framer check failed");

`endif

// ----- rtl/core/cpf_pkg.sv -----
package cpf_pkg;

    localparam logic [7:0]  SYNC_BYTE   = 8'h6E;
    localparam logic [15:0] CRC_POLY    = 16'h1021;
    localparam logic [15:0] CRC_TOP     = 16'h8000;
    localparam logic [15:0] COUNT_LIMIT = 16'd65525;

    // item kinds on the input channel
    localparam logic KIND_START = 1'b0;
    localparam logic KIND_ARG   = 1'b1;

    // work queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    // one unit of work for the byte sequencer
    typedef struct packed {
        logic        is_start;
        logic [7:0]  data;
        logic [15:0] count;
        logic        last;
    } cpf_op_t;

    // crc-16, poly 0x1021, msb first, one byte
    function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if ((c & CRC_TOP) != 16'h0000) begin
                c = (c << 1) ^ CRC_POLY;
            end else begin
                c = c << 1;
            end
        end
        return c;
    endfunction

endpackage

// ----- rtl/core/cpf_front.sv -----
module cpf_front (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  logic            s_kind,
    input  logic [7:0]      s_command_code,
    input  logic [15:0]     s_argument_count,
    input  logic [7:0]      s_argument_byte,
    output logic            push_valid,
    input  logic            push_ready,
    output cpf_pkg::cpf_op_t push_op
);
    import cpf_pkg::*;

    logic        open_reg, open_next;
    logic [15:0] remaining_reg, remaining_next;
    logic [15:0] count_sat;
    logic        accept;

    assign s_ready = push_ready;
    assign accept  = s_valid && s_ready;

    // clamp the length so the expected count stays in range
    assign count_sat = (s_argument_count > COUNT_LIMIT) ? COUNT_LIMIT : s_argument_count;

    // classify the item and track the open packet
    always_comb begin
        open_next      = open_reg;
        remaining_next = remaining_reg;
        push_valid     = 1'b0;
        push_op        = '0;
        if (s_kind == KIND_START) begin
            push_op.is_start = 1'b1;
            push_op.data     = s_command_code;
            push_op.count    = count_sat;
            push_op.last     = (count_sat == 16'd0);
            push_valid       = accept;
            if (accept) begin
                remaining_next = count_sat;
                open_next      = (count_sat != 16'd0);
            end
        end else begin
            push_op.is_start = 1'b0;
            push_op.data     = s_argument_byte;
            push_op.count    = remaining_reg;
            push_op.last     = (remaining_reg == 16'd1);
            push_valid       = accept && open_reg;
            if (accept && open_reg) begin
                remaining_next = remaining_reg - 16'd1;
                open_next      = (remaining_reg != 16'd1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            open_reg      <= 1'b0;
            remaining_reg <= 16'd0;
        end else begin
            open_reg      <= open_next;
            remaining_reg <= remaining_next;
        end
    end

endmodule

// ----- rtl/core/cpf_queue.sv -----
module cpf_queue (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push_valid,
    output logic             push_ready,
    input  cpf_pkg::cpf_op_t push_op,
    output logic             pop_valid,
    input  logic             pop_ready,
    output cpf_pkg::cpf_op_t pop_op
);
    import cpf_pkg::*;

    cpf_op_t             slot_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QUEUE_AW:0]   count_reg, count_next;
    logic                do_push, do_pop;

    assign push_ready = (count_reg != QUEUE_AW'(0) + (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_op     = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // occupancy
    always_comb begin
        count_next = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    // entry storage
    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_op;
        end
    end

endmodule

// ----- rtl/core/cpf_back.sv -----
module cpf_back (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             q_valid,
    output logic             q_ready,
    input  cpf_pkg::cpf_op_t q_op,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [7:0]       m_packet_byte,
    output logic             m_packet_end
);
    import cpf_pkg::*;
`include "command_packet_framer_crc16_core_macros.svh"

    // header steps
    localparam logic [2:0] STEP_SYNC     = 3'd0;
    localparam logic [2:0] STEP_ZERO_A   = 3'd1;
    localparam logic [2:0] STEP_ZERO_B   = 3'd2;
    localparam logic [2:0] STEP_CMD      = 3'd3;
    localparam logic [2:0] STEP_LEN_HI   = 3'd4;
    localparam logic [2:0] STEP_LEN_LO   = 3'd5;
    localparam logic [2:0] STEP_CRC1_HI  = 3'd6;
    localparam logic [2:0] STEP_CRC1_LO  = 3'd7;
    // argument steps
    localparam logic [2:0] STEP_ARG      = 3'd0;
    localparam logic [2:0] STEP_CRC2_HI  = 3'd1;
    localparam logic [2:0] STEP_CRC2_LO  = 3'd2;

    logic [2:0]  step_reg;
    logic [15:0] crc_reg;
    logic [7:0]  crc1_lo_reg;
    logic        m_valid_reg;
    logic [7:0]  m_byte_reg;
    logic        m_end_reg;

    logic [15:0] crc_base, crc_next;
    logic [7:0]  byte_sel;
    logic        byte_end, byte_final, byte_feed;
    logic        out_free, emit;

    assign out_free = !m_valid_reg || m_ready;
    assign emit     = q_valid && out_free;
    assign q_ready  = emit && byte_final;

    // a new header restarts the crc from zero
    assign crc_base = (q_op.is_start && step_reg == STEP_SYNC) ? 16'h0000 : crc_reg;

    // pick the byte for the current step
    always_comb begin
        byte_sel   = 8'h00;
        byte_end   = 1'b0;
        byte_final = 1'b0;
        byte_feed  = 1'b1;
        if (q_op.is_start) begin
            case (step_reg)
                STEP_SYNC:    byte_sel = SYNC_BYTE;
                STEP_ZERO_A:  byte_sel = 8'h00;
                STEP_ZERO_B:  byte_sel = 8'h00;
                STEP_CMD:     byte_sel = q_op.data;
                STEP_LEN_HI:  byte_sel = q_op.count[15:8];
                STEP_LEN_LO:  byte_sel = q_op.count[7:0];
                STEP_CRC1_HI: byte_sel = crc_base[15:8];
                STEP_CRC1_LO: begin
                    byte_sel   = crc1_lo_reg;
                    byte_end   = q_op.last;
                    byte_final = 1'b1;
                end
                default:      byte_sel = 8'h00;
            endcase
        end else begin
            case (step_reg)
                STEP_ARG: begin
                    byte_sel   = q_op.data;
                    byte_final = !q_op.last;
                end
                STEP_CRC2_HI: begin
                    byte_sel  = crc_base[15:8];
                    byte_feed = 1'b0;
                end
                STEP_CRC2_LO: begin
                    byte_sel   = crc_base[7:0];
                    byte_feed  = 1'b0;
                    byte_end   = 1'b1;
                    byte_final = 1'b1;
                end
                default: begin
                    byte_feed  = 1'b0;
                    byte_final = 1'b1;
                end
            endcase
        end
    end

    assign crc_next = byte_feed ? crc_feed(crc_base, byte_sel) : crc_base;

    // sequencer and crc state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= STEP_SYNC;
            crc_reg  <= 16'h0000;
        end else if (emit) begin
            crc_reg  <= crc_next;
            step_reg <= byte_final ? STEP_SYNC : step_reg + 3'd1;
        end
    end

    // header crc low byte, kept before the high byte is folded in
    always_ff @(posedge aclk) begin
        if (emit && q_op.is_start && step_reg == STEP_CRC1_HI) begin
            crc1_lo_reg <= crc_base[7:0];
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_free) begin
            m_valid_reg <= emit;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            m_byte_reg <= byte_sel;
            m_end_reg  <= byte_end;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_packet_byte = m_byte_reg;
    assign m_packet_end  = m_end_reg;

    // a half-done operation keeps its queue entry
    `CPF_ASSERT_NOW(a_step_holds_entry, step_reg != STEP_SYNC, q_valid)
    // packet end is only flagged on an operation's final byte
    `CPF_ASSERT_NOW(a_end_is_final, emit && byte_end, q_ready)
    // argument without crc tail never advances past its byte
    `CPF_ASSERT_NOW(a_arg_single, q_valid && !q_op.is_start && !q_op.last, step_reg == STEP_ARG)
    // an emitted byte is presented on the next cycle
    `CPF_ASSERT_NEXT(a_emit_shows, emit, m_valid)

endmodule

// ----- rtl/core/command_packet_framer_crc16_core.sv -----
// Command packet framer with CRC-16 (poly 0x1021, init 0).
// Input channel s_*: kind 0 starts a packet with s_command_code and
// s_argument_count (clamped to 65525); kind 1 carries one s_argument_byte.
// Output channel m_*: one framed byte per transfer, m_packet_end on the last.
// A start yields 8 bytes (sync, 0, 0, command, length, CRC1); an argument
// yields 1 byte, or 3 on the last one (byte, CRC2 high, CRC2 low).
// Arguments outside an open packet are taken and dropped; a start abandons
// any open packet.
// With the queue empty, an accepted item is first written into the queue;
// its first byte then passes through the sequencer's output register.
// Throughput: one output byte per cycle while items wait in the queue and
// m_ready is high; the byte sequencer emits one byte each such cycle and
// folds all but the CRC2 bytes into the CRC, holding an item until its last byte.
// A 4-entry work queue sits between the input classifier and the sequencer,
// so items keep being taken while the sequencer works or m_ready is low;
// s_ready drops only when that queue is full.
// Reset (aresetn low, synchronous) empties the queue, closes any packet
// and drops the pending output byte.
module command_packet_framer_crc16_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_kind,
    input  logic [7:0]  s_command_code,
    input  logic [15:0] s_argument_count,
    input  logic [7:0]  s_argument_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_packet_byte,
    output logic        m_packet_end
);
    import cpf_pkg::*;

    logic    push_valid, push_ready;
    cpf_op_t push_op;
    logic    q_valid, q_ready;
    cpf_op_t q_op;

    // classify incoming transfers
    cpf_front u_front (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_kind           (s_kind),
        .s_command_code   (s_command_code),
        .s_argument_count (s_argument_count),
        .s_argument_byte  (s_argument_byte),
        .push_valid       (push_valid),
        .push_ready       (push_ready),
        .push_op          (push_op)
    );

    // work queue
    cpf_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_op    (push_op),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_op     (q_op)
    );

    // byte sequencer and crc
    cpf_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_valid       (q_valid),
        .q_ready       (q_ready),
        .q_op          (q_op),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_packet_byte (m_packet_byte),
        .m_packet_end  (m_packet_end)
    );

endmodule
